@@ rtl/ftr_pkg.sv @@
`timescale 1ns / 1ps

package ftr_pkg;

  localparam int COLUMNS   = 128;
  localparam int PAGES     = 4;
  localparam int BIG_SCALE = 2;
  localparam int GLYPH_W   = 5;

  localparam int DEPTH     = PAGES * COLUMNS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int PG_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int BIG_COLS  = GLYPH_W * BIG_SCALE;
  localparam int BIG_CNT_W = $clog2(BIG_COLS + 1);
  localparam int CNT_W     = (ADDR_W > BIG_CNT_W) ? ADDR_W : BIG_CNT_W;
  localparam int SUB_W     = $clog2(BIG_SCALE + 1);
  localparam int EXP_W     = 8 * BIG_SCALE;
  localparam int SPAN_W    = 8 * (BIG_SCALE + 1);

  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_BIG   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef struct packed {
    logic             cap;
    logic             clr_wr;
    logic             char_wr;
    logic             big_rd;
    logic             rd;
    logic             res_load;
    logic [CNT_W-1:0] cnt;
    logic [SUB_W-1:0] sub;
  } ftr_cmd_t;

  typedef struct packed {
    op_e  op;
    logic ign;
  } ftr_sts_t;

  // glyph columns packed with column 0 in the low byte
  localparam logic [39:0] FONT [43] = '{
    40'h7E1111117E, 40'h364949497F, 40'h224141413E, 40'h1C2241417F,
    40'h414949497F, 40'h010909097F, 40'h7A4949413E, 40'h7F0808087F,
    40'h00417F4100, 40'h013F414020, 40'h412214087F, 40'h404040407F,
    40'h7F020C027F, 40'h7F1008047F, 40'h3E4141413E, 40'h060909097F,
    40'h5E2151413E, 40'h462919097F, 40'h3149494946, 40'h01017F0101,
    40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h4345495161,
    40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
    40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
    40'h3649494936, 40'h1E29494906,
    40'h0000000000, 40'h0000604000, 40'h0000363600, 40'h00005F0000,
    40'h0808080808, 40'h4040404040, 40'h0609510102
  };

  localparam logic [5:0] GI_SPACE = 6'd36;
  localparam logic [5:0] GI_DOT   = 6'd37;
  localparam logic [5:0] GI_COLON = 6'd38;
  localparam logic [5:0] GI_BANG  = 6'd39;
  localparam logic [5:0] GI_DASH  = 6'd40;
  localparam logic [5:0] GI_UNDER = 6'd41;
  localparam logic [5:0] GI_QUEST = 6'd42;

  function automatic logic [39:0] font_glyph(input logic [7:0] code);
    logic [5:0] gi;
    if (code inside {[8'h61:8'h7A]}) begin
      gi = 6'(code - 8'h61);
    end else if (code inside {[8'h41:8'h5A]}) begin
      gi = 6'(code - 8'h41);
    end else if (code inside {[8'h30:8'h39]}) begin
      gi = 6'(code - 8'h30) + 6'd26;
    end else begin
      case (code)
        8'h20:   gi = GI_SPACE;
        8'h2E:   gi = GI_DOT;
        8'h3A:   gi = GI_COLON;
        8'h21:   gi = GI_BANG;
        8'h2D:   gi = GI_DASH;
        8'h5F:   gi = GI_UNDER;
        default: gi = GI_QUEST;
      endcase
    end
    return FONT[gi];
  endfunction

  function automatic logic [7:0] glyph_col(input logic [39:0] g, input logic [2:0] idx);
    logic [7:0] col;
    col = 8'h00;
    if (32'(idx) < GLYPH_W) col = g[idx*8 +: 8];
    return col;
  endfunction

  // doubles each glyph row into BIG_SCALE pixel rows
  function automatic logic [EXP_W-1:0] expand_col(input logic [7:0] col);
    logic [EXP_W-1:0] e;
    for (int b = 0; b < 8; b++) begin
      for (int s = 0; s < BIG_SCALE; s++) begin
        e[b*BIG_SCALE + s] = col[b];
      end
    end
    return e;
  endfunction

endpackage

@@ rtl/ftr_ctrl.sv @@
`timescale 1ns / 1ps

module ftr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              m_ready_i,
  output logic              m_valid_o,
  input  ftr_pkg::ftr_sts_t sts_i,
  output ftr_pkg::ftr_cmd_t cmd_o
);
  import ftr_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISP,
    ST_CHAR,
    ST_BIG,
    ST_READ,
    ST_CLEAR,
    ST_DONE
  } state_e;

  localparam logic [CNT_W-1:0] CNT_CLR_LAST  = CNT_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_CHAR_LAST = CNT_W'(GLYPH_W);
  localparam logic [CNT_W-1:0] CNT_BIG_LAST  = CNT_W'(BIG_COLS - 1);
  localparam logic [SUB_W-1:0] SUB_LAST      = SUB_W'(BIG_SCALE);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUB_W-1:0] sub_q, sub_d;
  logic             m_valid_q, m_valid_d;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    sub_d     = sub_q;
    m_valid_d = m_valid_q && !m_ready_i;
    cmd_o     = '0;
    cmd_o.cnt = cnt_q;
    cmd_o.sub = sub_q;
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CNT_CLR_LAST) begin
          cnt_d   = '0;
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        cmd_o.cap = s_valid_i;
        cnt_d     = '0;
        sub_d     = '0;
        if (s_valid_i) state_d = ST_DISP;
      end
      ST_DISP: begin
        case (sts_i.op)
          OP_CHAR:  state_d = sts_i.ign ? ST_DONE : ST_CHAR;
          OP_BIG:   state_d = sts_i.ign ? ST_DONE : ST_BIG;
          OP_CLEAR: state_d = ST_CLEAR;
          OP_READ:  state_d = sts_i.ign ? ST_DONE : ST_READ;
          default:  state_d = ST_DONE;
        endcase
      end
      ST_CHAR: begin
        cmd_o.char_wr = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CNT_CHAR_LAST) state_d = ST_DONE;
      end
      ST_BIG: begin
        // page offset is the inner loop, column offset the outer
        cmd_o.big_rd = 1'b1;
        sub_d        = sub_q + 1'b1;
        if (sub_q == SUB_LAST) begin
          sub_d = '0;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CNT_BIG_LAST) state_d = ST_DONE;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.res_load = 1'b1;
          m_valid_d      = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      cnt_q     <= '0;
      sub_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      sub_q     <= sub_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

endmodule

@@ rtl/ftr_datapath.sv @@
`timescale 1ns / 1ps

module ftr_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        op_i,
  input  logic [7:0]        col_x_i,
  input  logic [7:0]        row_y_i,
  input  logic [7:0]        char_code_i,
  input  ftr_pkg::ftr_cmd_t cmd_i,
  output ftr_pkg::ftr_sts_t sts_o,
  output logic [7:0]        read_data_o,
  output logic              ignored_o
);
  import ftr_pkg::*;

  logic [7:0]  mem_q [DEPTH];
  logic [7:0]  rdata_q;

  op_e         op_q;
  logic [7:0]  x_q;
  logic [7:0]  y_q;
  logic [39:0] glyph_q;

  logic        pend_q;
  logic [ADDR_W-1:0] wa_q;
  logic [7:0]  mask_q;

  logic [7:0]  read_data_q;
  logic        ignored_q;

  logic        page_out;
  logic        ign;

  always_comb begin
    page_out = (32'(y_q[7:3]) >= PAGES);
    case (op_q)
      OP_CHAR, OP_BIG: ign = page_out;
      OP_READ:         ign = page_out || (32'(x_q) >= COLUMNS);
      default:         ign = 1'b0;
    endcase
  end

  assign sts_o.op  = op_q;
  assign sts_o.ign = ign;

  // draw char: one column per step
  logic [8:0]        char_col;
  logic              char_ok;
  logic [ADDR_W-1:0] char_addr;
  logic [7:0]        char_data;

  always_comb begin
    char_col  = {1'b0, x_q} + 9'(cmd_i.cnt);
    char_ok   = (32'(char_col) < COLUMNS);
    char_addr = ADDR_W'(32'(y_q[3 +: PG_W]) * COLUMNS + 32'(char_col[COL_W-1:0]));
    char_data = glyph_col(glyph_q, 3'(cmd_i.cnt));
  end

  // scaled char: one byte of one column per step, read then or-in
  logic [8:0]        big_col;
  logic [5:0]        big_pg;
  logic              big_ok;
  logic [ADDR_W-1:0] big_addr;
  logic [SPAN_W-1:0] big_span;
  logic [7:0]        big_mask;

  always_comb begin
    big_col  = {1'b0, x_q} + 9'(cmd_i.cnt);
    big_pg   = 6'(y_q[7:3]) + 6'(cmd_i.sub);
    big_ok   = (32'(big_col) < COLUMNS) && (32'(big_pg) < PAGES);
    big_addr = ADDR_W'(32'(big_pg[PG_W-1:0]) * COLUMNS + 32'(big_col[COL_W-1:0]));
    big_span = SPAN_W'(expand_col(glyph_col(glyph_q, 3'(cmd_i.cnt / BIG_SCALE))))
               << y_q[2:0];
    big_mask = big_span[cmd_i.sub*8 +: 8];
  end

  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] read_addr;

  assign read_addr = ADDR_W'(32'(y_q[3 +: PG_W]) * COLUMNS + 32'(x_q[COL_W-1:0]));
  assign rd_addr   = cmd_i.big_rd ? big_addr : read_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem_q[cmd_i.cnt[ADDR_W-1:0]] <= 8'h00;
    end else if (cmd_i.char_wr && char_ok) begin
      mem_q[char_addr] <= char_data;
    end else if (pend_q) begin
      mem_q[wa_q] <= rdata_q | mask_q;
    end
    if (cmd_i.big_rd || cmd_i.rd) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.big_rd && big_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q    <= op_e'(op_i);
      x_q     <= col_x_i;
      y_q     <= row_y_i;
      glyph_q <= font_glyph(char_code_i);
    end
    if (cmd_i.big_rd) begin
      wa_q   <= big_addr;
      mask_q <= big_mask;
    end
    if (cmd_i.res_load) begin
      read_data_q <= (op_q == OP_READ && !ign) ? rdata_q : 8'h00;
      ignored_q   <= ign;
    end
  end

  assign read_data_o = read_data_q;
  assign ignored_o   = ignored_q;

endmodule

@@ rtl/font_text_framebuffer_renderer.sv @@
// a double-size char does one byte of read-modify-write per cycle over 10 columns and
// 3 pages, a clear writes one frame byte per cycle, and an ignored item goes
// straight to its result without touching the frame store
// throughput: one item at a time; the next word is taken in the cycle after the
// result is loaded; a result held by m_axis_tready stalls the following item
// reset: asynchronous, active low; frame store swept to zero after it
`timescale 1ns / 1ps

module font_text_framebuffer_renderer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // col_x[7:0], row_y[15:8], char_code[23:16]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // read_data[7:0]
  output logic        m_axis_tuser   // ignored[0]
);
  import ftr_pkg::*;

  ftr_cmd_t cmd;
  ftr_sts_t sts;

  ftr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ftr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (s_axis_tuser),
    .col_x_i     (s_axis_tdata[7:0]),
    .row_y_i     (s_axis_tdata[15:8]),
    .char_code_i (s_axis_tdata[23:16]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .read_data_o (m_axis_tdata),
    .ignored_o   (m_axis_tuser)
  );

endmodule

@@ tb/sv/tb_font_text_framebuffer_renderer.sv @@
`timescale 1ns / 1ps

module tb_font_text_framebuffer_renderer;
  import ftr_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 64;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 1750;
  localparam int STEADY_ITEMS = 100;

  // slots of the shadow font table
  localparam int SLOT_DIGIT   = 26;
  localparam int SLOT_SPACE   = 36;
  localparam int SLOT_DOT     = 37;
  localparam int SLOT_COLON   = 38;
  localparam int SLOT_BANG    = 39;
  localparam int SLOT_DASH    = 40;
  localparam int SLOT_UNDER   = 41;
  localparam int SLOT_UNKNOWN = 42;

  // column 0 in the top byte
  localparam logic [39:0] GLYPH_ROM [43] = '{
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
    40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
    40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
    40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
    40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E,
    40'h0000000000, 40'h0040600000, 40'h0036360000, 40'h00005F0000,
    40'h0808080808, 40'h4040404040, 40'h0201510906
  };

  typedef struct {
    logic [7:0] read_data;
    logic       ignored;
    int         seq;
  } frame_result_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // col_x[7:0], row_y[15:8], char_code[23:16]
  logic [1:0]  s_axis_tuser  = '0;  // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // read_data[7:0]
  logic        m_axis_tuser;        // ignored[0]

  logic [7:0]    shadow_frame [DEPTH];
  frame_result_t pending_results [$];
  int            mismatch_count = 0;
  int            words_sent     = 0;
  int            stuck_cycles   = 0;

  bit  steady     = 1'b0;
  bit  tx_idle_on = 1'b1;
  int  rx_hold_req   = 0;
  int  rx_hold_left  = 0;
  int  rx_stall_left = 0;
  int  rx_quiet_left = 0;
  logic [7:0] anchor_x = '0;
  logic [7:0] anchor_y = '0;

  font_text_framebuffer_renderer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int glyph_slot(input logic [7:0] code);
    int slot;
    if (code >= "a" && code <= "z") begin
      slot = code - "a";
    end else if (code >= "A" && code <= "Z") begin
      slot = code - "A";
    end else if (code >= "0" && code <= "9") begin
      slot = SLOT_DIGIT + (code - "0");
    end else begin
      case (code)
        " ":     slot = SLOT_SPACE;
        ".":     slot = SLOT_DOT;
        ":":     slot = SLOT_COLON;
        "!":     slot = SLOT_BANG;
        "-":     slot = SLOT_DASH;
        "_":     slot = SLOT_UNDER;
        default: slot = SLOT_UNKNOWN;
      endcase
    end
    return slot;
  endfunction

  // applies one command to the shadow frame and returns the expected word
  function automatic void frame_predict(input op_e op, input logic [7:0] x,
                                        input logic [7:0] y, input logic [7:0] code,
                                        output logic [7:0] rd, output logic ign);
    int unsigned page;
    int unsigned px;
    int unsigned py;
    logic [39:0] glyph;
    logic [7:0]  gcol;
    page  = y / 8;
    rd    = 8'h00;
    ign   = 1'b0;
    glyph = GLYPH_ROM[glyph_slot(code)];
    case (op)
      OP_CHAR: begin
        if (page >= PAGES) begin
          ign = 1'b1;
        end else begin
          for (int i = 0; i <= GLYPH_W; i++) begin
            px = x + i;
            if (px < COLUMNS)
              shadow_frame[page * COLUMNS + px] = (i < GLYPH_W) ? glyph[39 - 8 * i -: 8] : 8'h00;
          end
        end
      end
      OP_BIG: begin
        if (y >= PAGES * 8) begin
          ign = 1'b1;
        end else begin
          for (int gx = 0; gx < GLYPH_W; gx++) begin
            gcol = glyph[39 - 8 * gx -: 8];
            for (int gy = 0; gy < 8; gy++) begin
              if (gcol[gy]) begin
                for (int sx = 0; sx < BIG_SCALE; sx++) begin
                  for (int sy = 0; sy < BIG_SCALE; sy++) begin
                    px = x + gx * BIG_SCALE + sx;
                    py = y + gy * BIG_SCALE + sy;
                    if (px < COLUMNS && py < PAGES * 8)
                      shadow_frame[(py / 8) * COLUMNS + px][py % 8] = 1'b1;
                  end
                end
              end
            end
          end
        end
      end
      OP_CLEAR: begin
        foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      end
      default: begin
        if (page >= PAGES || x >= COLUMNS) ign = 1'b1;
        else rd = shadow_frame[page * COLUMNS + x];
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("mismatch at %0t: %s", $time, what);
  endtask

  // drives one word, waits for it to be taken and records what must come back
  task automatic send_word(input op_e op, input logic [7:0] x, input logic [7:0] y,
                           input logic [7:0] code);
    frame_result_t expected;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {code, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    frame_predict(op, x, y, code, expected.read_data, expected.ignored);
    expected.seq = words_sent;
    pending_results.push_back(expected);
    words_sent++;
    if (!steady && tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_code();
    string charset;
    charset = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789 .:!-_";
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return charset[$urandom_range(0, charset.len() - 1)];
  endfunction

  // mostly text drawn inside the frame followed by reads around it
  task automatic send_random_item();
    int unsigned pick;
    logic [7:0] x;
    logic [7:0] y;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      x = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(118, 140)) : 8'($urandom_range(0, 127));
      y = 8'($urandom_range(0, 31));
      anchor_x = x;
      anchor_y = y;
      send_word(OP_CHAR, x, y, pick_code());
    end else if (pick < 42) begin
      x = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(115, 140)) : 8'($urandom_range(0, 127));
      y = 8'($urandom_range(0, 31));
      anchor_x = x;
      anchor_y = y;
      send_word(OP_BIG, x, y, pick_code());
    end else if (pick < 44) begin
      send_word(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_code());
    end else if (pick < 90) begin
      x = anchor_x + 8'($urandom_range(0, 11));
      y = anchor_y + 8'($urandom_range(0, 2) * 8);
      send_word(OP_READ, x, y, 8'($urandom_range(0, 255)));
    end else begin
      send_word(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_directed_corners();
    send_word(OP_CHAR, 8'd0, 8'd0, "A");
    send_word(OP_CHAR, 8'd125, 8'd31, "z");
    send_word(OP_CHAR, 8'd255, 8'd8, "9");
    send_word(OP_CHAR, 8'd60, 8'd32, 8'hFF);
    send_word(OP_CHAR, 8'd60, 8'd255, 8'h00);
    send_word(OP_READ, 8'd0, 8'd0, 8'h00);
    send_word(OP_READ, 8'd127, 8'd31, 8'hFF);
    send_word(OP_READ, 8'd128, 8'd0, 8'h00);
    send_word(OP_READ, 8'd255, 8'd255, 8'h00);
    send_word(OP_BIG, 8'd0, 8'd17, "!");
    send_word(OP_BIG, 8'd120, 8'd31, "M");
    send_word(OP_BIG, 8'd200, 8'd0, ":");
    send_word(OP_BIG, 8'd10, 8'd32, "-");
    send_word(OP_READ, 8'd4, 8'd16, 8'h00);
    send_word(OP_READ, 8'd1, 8'd24, 8'h00);
    send_word(OP_CHAR, 8'd30, 8'd8, " ");
    send_word(OP_CHAR, 8'd36, 8'd9, ".");
    send_word(OP_CHAR, 8'd42, 8'd15, "_");
    send_word(OP_BIG, 8'd48, 8'd2, "?");
    send_word(OP_READ, 8'd37, 8'd8, 8'h00);
    send_word(OP_READ, 8'd50, 8'd8, 8'h00);
    send_word(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF);
    send_word(OP_READ, 8'd0, 8'd0, 8'h00);
    send_word(OP_READ, 8'd127, 8'd31, 8'h00);
    wait_drain();
  endtask

  // results pile up behind a long stall while the sender keeps offering words
  task automatic test_output_backpressure();
    rx_hold_req = LONG_HOLD;
    tx_idle_on  = 1'b0;
    repeat (24) send_random_item();
    tx_idle_on  = 1'b1;
    wait_drain();
  endtask

  task automatic test_random_text();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) tx_idle_on = ($urandom_range(0, 3) != 0);
      send_random_item();
      if (i % 400 == 399) wait_drain();
    end
    tx_idle_on = 1'b1;
    wait_drain();
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (STEADY_ITEMS) send_random_item();
    wait_drain();
  endtask

  // receiver: random stall bursts, quiet stretches and one long hold
  always @(posedge clk_i) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_quiet_left > 0) begin
      rx_quiet_left--;
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 39) == 0) begin
      rx_quiet_left = $urandom_range(20, 80);
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      rx_stall_left = $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    frame_result_t expected;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word data=%02h ignored=%0b",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        expected = pending_results.pop_front();
        if (m_axis_tdata !== expected.read_data)
          report_mismatch($sformatf("word %0d read_data %02h, want %02h",
                                    expected.seq, m_axis_tdata, expected.read_data));
        if (m_axis_tuser !== expected.ignored)
          report_mismatch($sformatf("word %0d ignored %0b, want %0b",
                                    expected.seq, m_axis_tuser, expected.ignored));
      end
    end
  end

  initial begin
    while (stuck_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_output_backpressure();
    test_random_text();
    test_steady_stream();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ font_text_framebuffer_renderer.f @@
rtl/ftr_pkg.sv
rtl/ftr_ctrl.sv
rtl/ftr_datapath.sv
rtl/font_text_framebuffer_renderer.sv
tb/sv/tb_font_text_framebuffer_renderer.sv
